FILE: design/page_frame_free_list_allocator_assert.svh
// Assertion macros used by the page frame allocator top-level RTL.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PFFL_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pffl: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PFFL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pffl: next-cycle check failed");

`endif

FILE: design/pffl_pkg.sv
// Shared types and constants of the page frame allocator.
package pffl_pkg;

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int FRAME_CAP      = 1024;
  localparam int MAX_REQUEST    = 64;

  localparam int ACTION_W = 2;
  localparam int REQ_W    = 7;
  localparam int FRAME_W  = 10;
  localparam int COUNT_W  = 10;
  localparam int TOTAL_W  = 11;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(1024);
  localparam logic [TOTAL_W-1:0] TOTAL_MIN   = TOTAL_W'(2);

  // Register word index, taken from paddr[2].
  localparam logic REG_IDX_TOTAL = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_POP_RD,
    ST_POP_WR
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [REQ_W-1:0]    request_count;
    logic [FRAME_W-1:0]  release_frame;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic [FRAME_W-1:0]  frame_index;
    logic                last;
    logic [COUNT_W-1:0]  available;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic fill_step;
    logic fill_done;
    logic alloc_commit;
    logic pop_read;
    logic pop_write;
    logic push;
    logic emit_fail;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    action_t action;
    logic    req_zero;
    logic    req_refused;
    logic    rel_invalid;
    logic    fill_last;
    logic    pop_last;
  } stat_t;

endpackage

FILE: design/page_frame_free_list_allocator.sv
// Release or refusal: the request is registered and decoded, then the result is registered; idle again after decode.
// Allocate of n frames: each frame is a link memory read, then the head frame is handed out
//   and its link cleared (the read feeds the next head); busy holds until the last frame is popped.
// Init: links frames 1 to total-1 one per cycle, then gives one result.
// Results are strobed for one cycle; the receiver cannot stall them.
// Synchronous active-low reset empties the list; link memory is left uninitialised.
`include "page_frame_free_list_allocator_assert.svh"

module page_frame_free_list_allocator #(
  parameter int MAX_FRAMES = pffl_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          start,
  output logic                          busy,
  input  pffl_pkg::in_item_t            in_cmd,
  // Result channel
  output logic                          out_valid,
  output pffl_pkg::out_item_t           out_result,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pffl_pkg::ADDR_W-1:0]   paddr,
  input  logic [pffl_pkg::DATA_W-1:0]   pwdata,
  output logic [pffl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import pffl_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic [TOTAL_W-1:0] frames_total_r;
  logic               cfg_wr;
  logic               cfg_hit;

  // Word index sits in paddr[2]; the low bits pick a byte lane and are ignored.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_IDX_TOTAL);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? DATA_W'(frames_total_r) : '0;

  // Hold the programmed total; the datapath clamps it where used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_total_r <= TOTAL_RESET;
    end else if (cfg_wr) begin
      frames_total_r <= pwdata[TOTAL_W-1:0];
    end
  end

  // Sequence each request: decode, then fill, pop, push or refuse.
  pffl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Link memory, list head, free count and the result register.
  pffl_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_cmd),
    .frames_total (frames_total_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_result   (out_result)
  );

  // A taken request always makes the sequencer busy in the next cycle.
  `PFFL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A refusal is always a single, final result.
  `PFFL_ASSERT_IMPLY(a_fail_last, out_valid && !out_result.ok, out_result.last)
  // More frames of a burst are still to come while the block is busy.
  `PFFL_ASSERT_IMPLY(a_burst_busy, out_valid && !out_result.last, busy)
  // A real frame index is only ever handed out on success.
  `PFFL_ASSERT_IMPLY(a_frame_ok, out_valid && (out_result.frame_index != '0), out_result.ok)

endmodule

FILE: design/pffl_ctrl.sv
// Sequencing state machine of the page frame allocator.
module pffl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  pffl_pkg::stat_t stat,
  output pffl_pkg::cmd_t  cmd,
  output logic            busy
);
  import pffl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.action)
          ACT_INIT: begin
            state_nxt = ST_FILL;
          end
          ACT_ALLOC: begin
            if (stat.req_zero) begin
              state_nxt = ST_IDLE;
            end else if (stat.req_refused) begin
              cmd.emit_fail = 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              cmd.alloc_commit = 1'b1;
              state_nxt        = ST_POP_RD;
            end
          end
          ACT_RELEASE: begin
            if (stat.rel_invalid) begin
              cmd.emit_fail = 1'b1;
            end else begin
              cmd.push = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
          default: begin
            cmd.emit_fail = 1'b1;
            state_nxt     = ST_IDLE;
          end
        endcase
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          cmd.fill_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_POP_RD: begin
        cmd.pop_read = 1'b1;
        state_nxt    = ST_POP_WR;
      end
      ST_POP_WR: begin
        cmd.pop_write = 1'b1;
        state_nxt     = stat.pop_last ? ST_IDLE : ST_POP_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/pffl_dp.sv
// Datapath of the page frame allocator: link memory, head, count and result register.
module pffl_dp #(
  parameter int MAX_FRAMES = pffl_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pffl_pkg::in_item_t             in_cmd,
  input  logic [pffl_pkg::TOTAL_W-1:0]   frames_total,
  input  pffl_pkg::cmd_t                 cmd,
  output pffl_pkg::stat_t                stat,
  output logic                           out_valid,
  output pffl_pkg::out_item_t            out_result
);
  import pffl_pkg::*;

  localparam int DEPTH  = (MAX_FRAMES < FRAME_CAP) ? MAX_FRAMES : FRAME_CAP;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LINK_W = IDX_W + 1;
  // Top bit set marks the end of the chain.
  localparam logic [LINK_W-1:0] END_LINK = {1'b1, {IDX_W{1'b0}}};
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = TOTAL_W'(DEPTH);

  logic [LINK_W-1:0] link_mem [DEPTH];
  logic [LINK_W-1:0] link_rd_r;

  in_item_t           in_r;
  logic [LINK_W-1:0]  head_r,     head_nxt;
  logic [COUNT_W-1:0] count_r,    count_nxt;
  logic [IDX_W-1:0]   fill_ptr_r, fill_ptr_nxt;
  logic [REQ_W-1:0]   rem_r,      rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_res_r,   out_res_nxt;

  logic [TOTAL_W-1:0] total_eff;
  logic [TOTAL_W-1:0] total_m1;
  logic [IDX_W-1:0]   head_idx;
  logic               head_end;
  logic [IDX_W-1:0]   rel_idx;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic               mem_re;

  // Clamp the programmed total to the managed range.
  always_comb begin
    if (frames_total < TOTAL_MIN) begin
      total_eff = TOTAL_MIN;
    end else if (frames_total > TOTAL_CAP) begin
      total_eff = TOTAL_CAP;
    end else begin
      total_eff = frames_total;
    end
  end

  assign total_m1 = total_eff - TOTAL_W'(1);
  assign head_idx = head_r[IDX_W-1:0];
  assign head_end = head_r[IDX_W];
  assign rel_idx  = in_r.release_frame[IDX_W-1:0];

  assign stat.action      = in_r.action;
  assign stat.req_zero    = (in_r.request_count == '0);
  assign stat.req_refused = (COUNT_W'(in_r.request_count) > count_r) ||
                            (in_r.request_count > REQ_W'(MAX_REQUEST));
  assign stat.rel_invalid = (in_r.release_frame == '0) ||
                            (TOTAL_W'(in_r.release_frame) >= total_eff);
  assign stat.fill_last   = (TOTAL_W'(fill_ptr_r) == total_m1);
  assign stat.pop_last    = (rem_r == REQ_W'(1));

  assign mem_re = cmd.pop_read && !head_end;

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    fill_ptr_nxt  = fill_ptr_r;
    rem_nxt       = rem_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_ptr_r;
    mem_wdata     = '0;

    if (cmd.capture) begin
      fill_ptr_nxt = IDX_W'(1);
    end

    if (cmd.fill_step) begin
      mem_we       = 1'b1;
      mem_waddr    = fill_ptr_r;
      mem_wdata    = stat.fill_last ? END_LINK :
                     {1'b0, IDX_W'(fill_ptr_r + IDX_W'(1))};
      fill_ptr_nxt = IDX_W'(fill_ptr_r + IDX_W'(1));
    end

    if (cmd.fill_done) begin
      head_nxt      = LINK_W'(1);
      count_nxt     = COUNT_W'(total_m1);
      out_valid_nxt = 1'b1;
      out_res_nxt   = '{ok: 1'b1, frame_index: '0, last: 1'b1,
                        available: COUNT_W'(total_m1)};
    end

    if (cmd.alloc_commit) begin
      count_nxt = count_r - COUNT_W'(in_r.request_count);
      rem_nxt   = in_r.request_count;
    end

    if (cmd.pop_write) begin
      rem_nxt       = rem_r - REQ_W'(1);
      out_valid_nxt = 1'b1;
      out_res_nxt   = '{ok: 1'b1, frame_index: '0, last: stat.pop_last,
                        available: count_r};
      if (!head_end) begin
        mem_we                  = 1'b1;
        mem_waddr               = head_idx;
        mem_wdata               = '0;
        head_nxt                = link_rd_r;
        out_res_nxt.frame_index = FRAME_W'(head_idx);
      end
    end

    if (cmd.push) begin
      mem_we        = 1'b1;
      mem_waddr     = rel_idx;
      mem_wdata     = head_r;
      head_nxt      = {1'b0, rel_idx};
      count_nxt     = (count_r != COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
      out_valid_nxt = 1'b1;
      out_res_nxt   = '{ok: 1'b1, frame_index: '0, last: 1'b1, available: count_nxt};
    end

    if (cmd.emit_fail) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = '{ok: 1'b0, frame_index: '0, last: 1'b1, available: count_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rd_r <= link_mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= END_LINK;
      count_r     <= '0;
      fill_ptr_r  <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fill_ptr_r  <= fill_ptr_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_cmd;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

endmodule
